// ===== sv/srlc_pkg.sv =====
// Shared types and constants for the segment register load check block.
// No dependencies; every other file in sv/ refers to this package.
package srlc_pkg;

  localparam int unsigned NUM_SEGS = 6;
  localparam int unsigned SEG_IDX_W = 3;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [31:0] INVALID_SPAN = 32'h0000_0000;
  localparam logic [31:0] REAL_SPAN = 32'h0000_FFFF;
  localparam logic [15:0] ERR_MASK = 16'hFFFC;
  localparam logic [15:0] LDT_IDX_MASK = 16'hFFF8;
  localparam logic [15:0] NULL_SEL_MAX = 16'h0003;

  localparam logic [SEG_IDX_W-1:0] SEG_ES = 3'd0;
  localparam logic [SEG_IDX_W-1:0] SEG_CS = 3'd1;
  localparam logic [SEG_IDX_W-1:0] SEG_SS = 3'd2;
  localparam logic [SEG_IDX_W-1:0] SEG_GS = 3'd5;

  typedef enum logic [1:0] {
    REG_LDT_PRESENT = 2'd0,
    REG_LDT_LIMIT   = 2'd1,
    REG_NULL_BASE   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_LOADED = 3'd0,
    ST_CACHED = 3'd1,
    ST_GPF    = 3'd2,
    ST_STACK  = 3'd3,
    ST_NOSEG  = 3'd4
  } status_t;

  typedef enum logic {
    ACT_REAL = 1'b0,
    ACT_PROT = 1'b1
  } action_t;

  typedef struct packed {
    logic        action;
    logic [2:0]  seg_index;
    logic [15:0] selector;
    logic        desc_user;
    logic        desc_present;
    logic        desc_code;
    logic        desc_readable;
    logic        desc_big;
    logic [31:0] desc_base;
    logic [31:0] desc_limit;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] error_code;
    logic [31:0] bound_low;
    logic [31:0] bound_high;
    logic        set_accessed;
    logic        stack_is_32;
    logic        code_is_32;
  } out_word_t;

  typedef struct packed {
    logic        ldt_present;
    logic [15:0] ldt_limit;
    logic [31:0] null_base;
  } cfg_t;

  typedef struct packed {
    logic        valid_idx;
    logic [15:0] sel;
    logic [31:0] lo;
    logic [31:0] hi;
    logic        stack_big;
    logic        code_big;
  } seg_rd_t;

  typedef struct packed {
    logic                 we;
    logic [SEG_IDX_W-1:0] idx;
    logic [15:0]          sel;
    logic [31:0]          lo;
    logic [31:0]          hi;
    logic                 ss_we;
    logic                 cs_we;
    logic                 big;
  } seg_wr_t;

endpackage

// ===== sv/srlc_cfg_regs.sv =====
// APB-style configuration registers: LDT presence, LDT limit, null base.
// Depends on srlc_pkg.
module srlc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srlc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [srlc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [srlc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output srlc_pkg::cfg_t                   cfg
);

  srlc_pkg::cfg_t cfg_r, cfg_nxt;
  logic [1:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        srlc_pkg::REG_LDT_PRESENT: cfg_nxt.ldt_present = pwdata[0];
        srlc_pkg::REG_LDT_LIMIT:   cfg_nxt.ldt_limit   = pwdata[15:0];
        srlc_pkg::REG_NULL_BASE:   cfg_nxt.null_base   = pwdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      srlc_pkg::REG_LDT_PRESENT: prdata = {31'd0, cfg_r.ldt_present};
      srlc_pkg::REG_LDT_LIMIT:   prdata = {16'd0, cfg_r.ldt_limit};
      srlc_pkg::REG_NULL_BASE:   prdata = cfg_r.null_base;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/srlc_seg_file.sv =====
// Six segment registers (selector and bounds) plus stack and code width flags.
// Depends on srlc_pkg.
module srlc_seg_file (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [srlc_pkg::SEG_IDX_W-1:0]    rd_idx,
  output srlc_pkg::seg_rd_t                 rd,
  input  srlc_pkg::seg_wr_t                 wr
);

  logic [15:0] sel_r [srlc_pkg::NUM_SEGS];
  logic [31:0] lo_r  [srlc_pkg::NUM_SEGS];
  logic [31:0] hi_r  [srlc_pkg::NUM_SEGS];
  logic        stack_big_r, code_big_r;
  logic        idx_ok;

  assign idx_ok = (rd_idx <= srlc_pkg::SEG_GS);

  always_comb begin
    rd.valid_idx = idx_ok;
    rd.stack_big = stack_big_r;
    rd.code_big  = code_big_r;
    if (idx_ok) begin
      rd.sel = sel_r[rd_idx];
      rd.lo  = lo_r[rd_idx];
      rd.hi  = hi_r[rd_idx];
    end else begin
      rd.sel = '0;
      rd.lo  = '0;
      rd.hi  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < srlc_pkg::NUM_SEGS; i++) begin
        sel_r[i] <= '0;
        lo_r[i]  <= '0;
        hi_r[i]  <= '0;
      end
      stack_big_r <= 1'b0;
      code_big_r  <= 1'b0;
    end else begin
      if (wr.we) begin
        sel_r[wr.idx] <= wr.sel;
        lo_r[wr.idx]  <= wr.lo;
        hi_r[wr.idx]  <= wr.hi;
      end
      if (wr.ss_we) begin
        stack_big_r <= wr.big;
      end
      if (wr.cs_we) begin
        code_big_r <= wr.big;
      end
    end
  end

endmodule

// ===== sv/srlc_check.sv =====
// Load decision: real-mode bounds, cached reload and the protected-mode check chain.
// Depends on srlc_pkg; reads the segment file and configuration, drives its write port.
module srlc_check (
  input  srlc_pkg::in_word_t   item,
  input  srlc_pkg::cfg_t       cfg,
  input  srlc_pkg::seg_rd_t    rd,
  input  logic                 go,
  output srlc_pkg::out_word_t  res,
  output srlc_pkg::seg_wr_t    wr
);

  logic [31:0] real_lo, real_hi, prot_hi, span;
  logic [15:0] err;
  logic        is_cs, is_ss, cached, ldt_bad;

  assign is_cs   = (item.seg_index == srlc_pkg::SEG_CS);
  assign is_ss   = (item.seg_index == srlc_pkg::SEG_SS);
  assign real_lo = {12'd0, item.selector, 4'd0};
  assign real_hi = real_lo + srlc_pkg::REAL_SPAN;
  assign prot_hi = item.desc_base + item.desc_limit;
  assign span    = rd.hi - rd.lo;
  assign cached  = (rd.sel == item.selector) && (span != srlc_pkg::INVALID_SPAN);
  assign err     = item.selector & srlc_pkg::ERR_MASK;
  assign ldt_bad = !cfg.ldt_present || !item.desc_user ||
                   ((item.selector & srlc_pkg::LDT_IDX_MASK) > cfg.ldt_limit);

  always_comb begin
    res.status       = srlc_pkg::ST_GPF;
    res.error_code   = err;
    res.bound_low    = rd.lo;
    res.bound_high   = rd.hi;
    res.set_accessed = 1'b0;
    res.stack_is_32  = rd.stack_big;
    res.code_is_32   = rd.code_big;
    wr.we    = 1'b0;
    wr.idx   = item.seg_index;
    wr.sel   = item.selector;
    wr.lo    = item.desc_base;
    wr.hi    = prot_hi;
    wr.ss_we = 1'b0;
    wr.cs_we = 1'b0;
    wr.big   = item.desc_big;

    priority if (!rd.valid_idx) begin
      res.error_code = '0;
      res.bound_low  = '0;
      res.bound_high = '0;
    end else if (item.action == srlc_pkg::ACT_REAL) begin
      res.status     = srlc_pkg::ST_LOADED;
      res.error_code = '0;
      res.bound_low  = real_lo;
      res.bound_high = real_hi;
      wr.we = 1'b1;
      wr.lo = real_lo;
      wr.hi = real_hi;
    end else if (cached) begin
      res.status     = srlc_pkg::ST_CACHED;
      res.error_code = '0;
    end else if (item.selector <= srlc_pkg::NULL_SEL_MAX) begin
      if (!(is_cs || is_ss)) begin
        res.status     = srlc_pkg::ST_LOADED;
        res.error_code = '0;
        res.bound_low  = cfg.null_base;
        res.bound_high = cfg.null_base;
        wr.we = 1'b1;
        wr.lo = cfg.null_base;
        wr.hi = cfg.null_base;
      end
    end else if (!item.selector[2] || ldt_bad) begin
      res.status = srlc_pkg::ST_GPF;
    end else if (!item.desc_present) begin
      res.status = is_ss ? srlc_pkg::ST_STACK : srlc_pkg::ST_NOSEG;
    end else if (is_cs ? !item.desc_code : (item.desc_code && !item.desc_readable)) begin
      res.status = srlc_pkg::ST_GPF;
    end else begin
      res.status       = srlc_pkg::ST_LOADED;
      res.error_code   = '0;
      res.bound_low    = item.desc_base;
      res.bound_high   = prot_hi;
      res.set_accessed = 1'b1;
      wr.we    = 1'b1;
      wr.ss_we = is_ss;
      wr.cs_we = is_cs;
      if (is_ss) begin
        res.stack_is_32 = item.desc_big;
      end
      if (is_cs) begin
        res.code_is_32 = item.desc_big;
      end
    end

    wr.we    = wr.we && go;
    wr.ss_we = wr.ss_we && go;
    wr.cs_we = wr.cs_we && go;
  end

endmodule

// ===== sv/segment_register_load_check.sv =====
// Top level of the segment register load check block.
// Depends on srlc_pkg, srlc_cfg_regs, srlc_seg_file and srlc_check.
//
// Usage:
//   in_valid/in_stall/in_data carry one load request word (register index,
//   selector, real/protected mode and the fetched descriptor fields). A word
//   is taken when in_valid is high and in_stall is low.
//   out_valid/out_stall/out_data return one result word per request: status,
//   error code, the register's bounds after the load, the accessed-bit request
//   and the current stack and code widths.
//   The APB-style port (psel, penable, pwrite, paddr, pwdata, prdata, pready)
//   sets ldt_present at 0x0, ldt_limit at 0x4 and null_base at 0x8; pready is
//   tied high. Write it only while no load is in flight.
// Timing: a word sits in the input register, where the segment file is read, checked
//   and written, then lands in the output register, where out_valid rises. One word
//   per cycle is sustained while out_stall stays low, since each load sees the segment
//   file as left by the one before.
// Reset (synchronous, rst_n low) clears all segment registers, width flags,
//   configuration and both valid flags. When out_stall holds the output word,
//   the input register still fills; in_stall rises only when both are full.
module segment_register_load_check (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  srlc_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output srlc_pkg::out_word_t              out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srlc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [srlc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [srlc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  srlc_pkg::cfg_t      cfg;
  srlc_pkg::seg_rd_t   rd;
  srlc_pkg::seg_wr_t   wr;
  srlc_pkg::in_word_t  s1_data_r;
  srlc_pkg::out_word_t res, out_data_r;
  logic s1_valid_r, s1_valid_nxt, out_valid_r, out_valid_nxt;
  logic out_free, advance, in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  srlc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srlc_seg_file u_segs (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (s1_data_r.seg_index),
    .rd     (rd),
    .wr     (wr)
  );

  srlc_check u_check (
    .item (s1_data_r),
    .cfg  (cfg),
    .rd   (rd),
    .go   (advance),
    .res  (res),
    .wr   (wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid_r))
    else $error("input stalled while a stage is free");

  a_no_write_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we || wr.ss_we || wr.cs_we) |-> advance)
    else $error("segment file written without a word moving out");

  a_fault_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != srlc_pkg::ST_LOADED) |->
      (!out_data.set_accessed))
    else $error("accessed bit requested on a rejected or cached load");

  a_ok_no_errcode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == srlc_pkg::ST_LOADED ||
                   out_data.status == srlc_pkg::ST_CACHED)) |->
      (out_data.error_code == 16'd0))
    else $error("error code on a successful load");

  a_widths_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!wr.ss_we && !wr.cs_we) |=> ($stable(rd.stack_big) && $stable(rd.code_big)))
    else $error("width flag changed without an SS or CS load");

endmodule

// ===== tb/tb_segment_register_load_check.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for segment_register_load_check: directed and random segment loads,
// predicted in-line and compared word by word. Needs srlc_pkg and the block's RTL only.
module tb_segment_register_load_check;

  localparam logic [srlc_pkg::SEG_IDX_W-1:0] SEG_DS = 3'd3;
  localparam logic [srlc_pkg::SEG_IDX_W-1:0] SEG_FS = 3'd4;
  localparam logic [srlc_pkg::SEG_IDX_W-1:0] SEG_BAD_LO = 3'd6;
  localparam logic [srlc_pkg::SEG_IDX_W-1:0] SEG_BAD_HI = 3'd7;

  // descriptor attributes: {user, present, code, readable, big}
  localparam logic [4:0] ATTR_DATA = 5'b11000;
  localparam logic [4:0] ATTR_CODE_RD = 5'b11110;
  localparam logic [4:0] ATTR_CODE_NR = 5'b11100;
  localparam logic [4:0] ATTR_ABSENT = 5'b10000;
  localparam logic [4:0] ATTR_SYSTEM = 5'b01000;
  localparam logic [4:0] ATTR_BIG = 5'b00001;

  localparam int HOLD_CYCLES = 50;
  localparam int WATCHDOG_CYCLES = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  srlc_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  srlc_pkg::out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [srlc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [srlc_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [srlc_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  segment_register_load_check u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // shadow of the segment file and LDT registers
  logic [15:0] seg_sel[srlc_pkg::NUM_SEGS] = '{default: '0};
  logic [31:0] seg_lo[srlc_pkg::NUM_SEGS] = '{default: '0};
  logic [31:0] seg_hi[srlc_pkg::NUM_SEGS] = '{default: '0};
  logic stack_big = 1'b0;
  logic code_big = 1'b0;
  srlc_pkg::cfg_t ldt_cfg = '0;

  srlc_pkg::out_word_t pending_results[$];
  int fail_count = 0;
  int n_loads = 0;
  int n_loaded = 0;
  int n_cached = 0;
  int n_faulted = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic srlc_pkg::out_word_t predict_load(input srlc_pkg::in_word_t w);
    srlc_pkg::out_word_t res;
    int unsigned r;
    res = '0;
    res.status = srlc_pkg::ST_LOADED;
    r = w.seg_index;
    if (r >= srlc_pkg::NUM_SEGS) begin
      res.status = srlc_pkg::ST_GPF;
    end else begin
      if (w.action == srlc_pkg::ACT_REAL) begin
        res.bound_low = {12'd0, w.selector, 4'd0};
        res.bound_high = res.bound_low + srlc_pkg::REAL_SPAN;
      end else if (seg_sel[r] == w.selector
                   && seg_hi[r] - seg_lo[r] != srlc_pkg::INVALID_SPAN) begin
        res.status = srlc_pkg::ST_CACHED;
      end else if (w.selector <= srlc_pkg::NULL_SEL_MAX) begin
        if (r == srlc_pkg::SEG_CS || r == srlc_pkg::SEG_SS) begin
          res.status = srlc_pkg::ST_GPF;
        end else begin
          res.bound_low = ldt_cfg.null_base;
          res.bound_high = ldt_cfg.null_base;
        end
      end else if (!w.selector[2] || !ldt_cfg.ldt_present || !w.desc_user
                   || (w.selector & srlc_pkg::LDT_IDX_MASK) > ldt_cfg.ldt_limit) begin
        res.status = srlc_pkg::ST_GPF;
      end else if (!w.desc_present) begin
        res.status = (r == srlc_pkg::SEG_SS) ? srlc_pkg::ST_STACK : srlc_pkg::ST_NOSEG;
      end else if ((r == srlc_pkg::SEG_CS) ? !w.desc_code
                                           : (w.desc_code && !w.desc_readable)) begin
        res.status = srlc_pkg::ST_GPF;
      end else begin
        res.bound_low = w.desc_base;
        res.bound_high = w.desc_base + w.desc_limit;
        res.set_accessed = 1'b1;
        if (r == srlc_pkg::SEG_SS) stack_big = w.desc_big;
        else if (r == srlc_pkg::SEG_CS) code_big = w.desc_big;
      end
      if (res.status == srlc_pkg::ST_LOADED) begin
        seg_sel[r] = w.selector;
        seg_lo[r] = res.bound_low;
        seg_hi[r] = res.bound_high;
      end else begin
        res.bound_low = seg_lo[r];
        res.bound_high = seg_hi[r];
        if (res.status != srlc_pkg::ST_CACHED) res.error_code = w.selector & srlc_pkg::ERR_MASK;
      end
    end
    res.stack_is_32 = stack_big;
    res.code_is_32 = code_big;
    return res;
  endfunction

  function automatic srlc_pkg::in_word_t make_load(input srlc_pkg::action_t act,
                                                   input logic [2:0] seg,
                                                   input logic [15:0] sel,
                                                   input logic [4:0] attr,
                                                   input logic [31:0] base,
                                                   input logic [31:0] limit);
    srlc_pkg::in_word_t w;
    w.action = act;
    w.seg_index = seg;
    w.selector = sel;
    {w.desc_user, w.desc_present, w.desc_code, w.desc_readable, w.desc_big} = attr;
    w.desc_base = base;
    w.desc_limit = limit;
    return w;
  endfunction

  // mostly well-formed LDT loads; the rest real mode, reloads, nulls, bad indexes and noise
  function automatic srlc_pkg::in_word_t random_load();
    srlc_pkg::in_word_t w;
    int unsigned pick;
    int unsigned slot;
    w.action = srlc_pkg::ACT_PROT;
    w.seg_index = 3'($urandom_range(srlc_pkg::SEG_GS));
    w.selector = 16'($urandom);
    {w.desc_user, w.desc_present, w.desc_code, w.desc_readable, w.desc_big} = 5'($urandom);
    w.desc_base = $urandom;
    w.desc_limit = ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF) : $urandom;
    pick = $urandom_range(99);
    if (pick < 8) begin
      w.action = srlc_pkg::ACT_REAL;
    end else if (pick < 11) begin
      w.action = srlc_pkg::action_t'($urandom_range(1));
      w.seg_index = 3'($urandom_range(SEG_BAD_HI, SEG_BAD_LO));
    end else if (pick < 23) begin
      w.selector = seg_sel[w.seg_index];
    end else if (pick < 31) begin
      w.selector = 16'($urandom_range(srlc_pkg::NULL_SEL_MAX));
    end else if (pick >= 41) begin
      slot = $urandom_range(ldt_cfg.ldt_limit >> 3);
      w.selector = {13'(slot), 1'b1, 2'($urandom)};
      w.desc_user = ($urandom_range(19) != 0);
      w.desc_present = ($urandom_range(9) != 0);
      w.desc_code = (w.seg_index == srlc_pkg::SEG_CS) ? ($urandom_range(9) != 0)
                                                      : ($urandom_range(3) == 0);
      w.desc_readable = ($urandom_range(4) != 0);
    end
    return w;
  endfunction

  function automatic string word_str(input srlc_pkg::out_word_t w);
    return $sformatf("st=%0d err=%h lo=%h hi=%h acc=%b ss32=%b cs32=%b", w.status,
                     w.error_code, w.bound_low, w.bound_high, w.set_accessed,
                     w.stack_is_32, w.code_is_32);
  endfunction

  task automatic send_load(input srlc_pkg::in_word_t w);
    srlc_pkg::out_word_t want;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = predict_load(w);
    pending_results.push_back(want);
    n_loads++;
    case (want.status)
      srlc_pkg::ST_LOADED: n_loaded++;
      srlc_pkg::ST_CACHED: n_cached++;
      default: n_faulted++;
    endcase
  endtask

  task automatic send_random_loads(input int count);
    repeat (count) send_load(random_load());
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write, then read back over the APB port
  task automatic write_ldt_reg(input srlc_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] readback;
    case (idx)
      srlc_pkg::REG_LDT_PRESENT: begin
        ldt_cfg.ldt_present = value[0];
        readback = {31'd0, value[0]};
      end
      srlc_pkg::REG_LDT_LIMIT: begin
        ldt_cfg.ldt_limit = value[15:0];
        readback = {16'd0, value[15:0]};
      end
      default: begin
        ldt_cfg.null_base = value;
        readback = value;
      end
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== readback) begin
      fail_count++;
      if (fail_count <= 10)
        $display("register %s readback: expected %h, got %h", idx.name(), readback, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_ldt_setting(input logic present, input logic [15:0] limit,
                                   input logic [31:0] nbase);
    wait_results_drained();
    write_ldt_reg(srlc_pkg::REG_LDT_PRESENT, {31'd0, present});
    write_ldt_reg(srlc_pkg::REG_LDT_LIMIT, {16'd0, limit});
    write_ldt_reg(srlc_pkg::REG_NULL_BASE, nbase);
  endtask

  // reset state: no LDT, all spans invalid
  task automatic test_real_mode_loads();
    send_load(make_load(srlc_pkg::ACT_REAL, srlc_pkg::SEG_ES, 16'hFFFF, ATTR_DATA, 32'h0, 32'h0));
    send_load(make_load(srlc_pkg::ACT_REAL, srlc_pkg::SEG_CS, 16'h0000, ATTR_DATA, 32'h0, 32'h0));
    send_load(make_load(srlc_pkg::ACT_REAL, srlc_pkg::SEG_GS, 16'h1234, ATTR_DATA, 32'h0, 32'h0));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_BAD_LO, 16'h0014, ATTR_DATA, 32'h1000, 32'hFF));
    send_load(make_load(srlc_pkg::ACT_REAL, SEG_BAD_HI, 16'hFFFF, ATTR_DATA, 32'h0, 32'h0));
    send_load(make_load(srlc_pkg::ACT_REAL, srlc_pkg::SEG_SS, 16'hABCD, ATTR_DATA, 32'h0, 32'h0));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_SS, 16'hABCD, ATTR_DATA, 32'h0, 32'h0));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_DS, 16'h0000, ATTR_DATA, 32'h0, 32'h0));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_SS, 16'h000C, ATTR_DATA, 32'h0,
                        32'hFFFF));
  endtask

  task automatic test_protected_checks();
    apply_ldt_setting(1'b1, 16'hFFFF, 32'hA5A5_0000);
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_CS, 16'h0003, ATTR_CODE_RD, 32'h0,
                        32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_SS, 16'h0002, ATTR_DATA, 32'h0,
                        32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_FS, 16'h0001, ATTR_DATA, 32'h0, 32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_FS, 16'h0001, ATTR_DATA, 32'h0, 32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_DS, 16'h0010, ATTR_DATA, 32'h0, 32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_DS, 16'h000F, ATTR_SYSTEM, 32'h0, 32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_SS, 16'h0007, ATTR_ABSENT, 32'h0,
                        32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_ES, 16'h0007, ATTR_ABSENT, 32'h0,
                        32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_CS, 16'h000C, ATTR_DATA, 32'h0,
                        32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_DS, 16'h0014, ATTR_CODE_NR, 32'h0, 32'hFFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_DS, 16'h0014, ATTR_CODE_RD, 32'hFFFF_FFF0,
                        32'h20));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_DS, 16'h0014, ATTR_CODE_RD, 32'h0, 32'h0));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_SS, 16'h001C, ATTR_DATA | ATTR_BIG,
                        32'h8000, 32'hFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_CS, 16'hFFFF, ATTR_CODE_NR | ATTR_BIG,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_ES, 16'h0004, ATTR_DATA,
                        32'h1234_5678, 32'h0));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_ES, 16'h0004, ATTR_DATA,
                        32'h1234_5678, 32'h0));
    send_load(make_load(srlc_pkg::ACT_PROT, srlc_pkg::SEG_GS, 16'h0024, ATTR_CODE_RD,
                        32'h0010_0000, 32'hFFFFF));
  endtask

  task automatic test_ldt_settings();
    apply_ldt_setting(1'b1, 16'h0008, 32'hFFFF_FFFF);
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_DS, 16'h000C, ATTR_DATA, 32'h2000, 32'h7F));
    send_load(make_load(srlc_pkg::ACT_PROT, SEG_DS, 16'h0014, ATTR_DATA, 32'h2000, 32'h7F));
    send_random_loads(100);
    apply_ldt_setting(1'b1, 16'hFFFF, 32'h0000_0000);
    send_random_loads(100);
    apply_ldt_setting(1'b0, 16'($urandom), $urandom);
    send_random_loads(100);
    apply_ldt_setting(1'b1, 16'h0000, $urandom);
    send_random_loads(100);
  endtask

  task automatic test_handshake_phases();
    apply_ldt_setting(1'b1, 16'h0FFF, $urandom);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_random_loads(80);
    tx_idle_pct = 66;
    send_random_loads(80);
    tx_idle_pct = 0;
    rx_stall_pct = 66;
    send_random_loads(80);
    tx_idle_pct = 14;
    rx_stall_pct = 14;
    send_random_loads(80);
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_reqs++;
    send_random_loads(60);
    wait_results_drained();
    send_random_loads(20);
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    srlc_pkg::out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result word with none pending: %s", word_str(out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.error_code !== want.error_code
            || out_data.bound_low !== want.bound_low || out_data.bound_high !== want.bound_high
            || out_data.set_accessed !== want.set_accessed
            || out_data.stack_is_32 !== want.stack_is_32
            || out_data.code_is_32 !== want.code_is_32) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch\n  expected %s\n  got      %s", word_str(want), word_str(out_data));
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_real_mode_loads();
    test_protected_checks();
    test_ldt_settings();
    test_handshake_phases();
    test_output_backpressure();
    wait_results_drained();
    $display("%0d load words: %0d loaded, %0d cached, %0d faulted; %0d mismatches", n_loads,
             n_loaded, n_cached, n_faulted, fail_count);
    $display("covered real and protected loads, six LDT settings, idle/stall mixes, long hold");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
